/* sv/ksd_pkg.sv */
// Shared types and constants for the set-1 scancode queue and decoder.
// No dependencies; the RTL files that use it refer to it by scoped names.
package ksd_pkg;

	typedef struct packed {
		logic       operation;
		logic [7:0] scancode;
	} ksd_in_t;

	typedef struct packed {
		logic       accepted;
		logic       key_ready;
		logic [6:0] key_code;
		logic       released;
		logic       extended;
		logic [7:0] character;
	} ksd_out_t;

	localparam logic       OP_PUSH     = 1'b0;
	localparam logic       OP_POLL     = 1'b1;
	localparam logic [7:0] PREFIX_EXT  = 8'hE0;
	localparam logic [7:0] CHAR_NONE   = 8'hFF;
	localparam logic [6:0] KEY_UP      = 7'h48;
	localparam logic [6:0] KEY_DOWN    = 7'h50;
	localparam logic [6:0] KEY_LEFT    = 7'h4B;
	localparam logic [6:0] KEY_RIGHT   = 7'h4D;
	localparam logic [7:0] CHAR_UP     = 8'hAD;
	localparam logic [7:0] CHAR_DOWN   = 8'hAF;
	localparam logic [7:0] CHAR_LEFT   = 8'hAC;
	localparam logic [7:0] CHAR_RIGHT  = 8'hAE;
	localparam int         TABLE_LEN   = 89;

	localparam logic [7:0] CHAR_TABLE [0:TABLE_LEN-1] = '{
		8'hFF, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h7F, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h9D, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'hB6, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'hB6, 8'h2A,
		8'hB8, 8'h20, 8'h20, 8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF,
		8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'h20, 8'h20, 8'h37,
		8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2E, 8'h20, 8'h20, 8'h20, 8'hD7,
		8'hD8
	};

endpackage

/* sv/ksd_ram.sv */
// Ring buffer storage: one write port, one read port, registered read data.
// No package dependencies.
module ksd_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* sv/ksd_decode.sv */
// Splits an event byte into key code and release flag and maps it to a character.
// Depends on ksd_pkg for the result type and the character table.
module ksd_decode (
	input  logic             [7:0] ev,
	input  logic                   ext,
	output ksd_pkg::ksd_out_t      res
);

	logic [6:0] key;
	logic [7:0] chr;

	assign key = ev[6:0];

	always_comb begin
		chr = ksd_pkg::CHAR_NONE;
		priority if (ext && key == ksd_pkg::KEY_UP) begin
			chr = ksd_pkg::CHAR_UP;
		end else if (ext && key == ksd_pkg::KEY_DOWN) begin
			chr = ksd_pkg::CHAR_DOWN;
		end else if (ext && key == ksd_pkg::KEY_LEFT) begin
			chr = ksd_pkg::CHAR_LEFT;
		end else if (ext && key == ksd_pkg::KEY_RIGHT) begin
			chr = ksd_pkg::CHAR_RIGHT;
		end else if (key < 7'(ksd_pkg::TABLE_LEN)) begin
			chr = ksd_pkg::CHAR_TABLE[key];
		end else begin
			chr = ksd_pkg::CHAR_NONE;
		end
	end

	always_comb begin
		res           = '0;
		res.key_ready = 1'b1;
		res.key_code  = key;
		res.released  = ev[7];
		res.extended  = ext;
		res.character = chr;
	end

endmodule

/* sv/keyboard_scancode_fifo_decoder.sv */
// A push gives its result in the cycle after acceptance and busy stays low.
// A poll on an empty queue answers in the cycle after acceptance; other polls first read
// the head byte from RAM, and the next byte when the head is a prefix with more queued.
// Throughput: one push per cycle when idle; a poll holds busy until it gives its result.
// The result strobe lasts one cycle. Reset empties the queue; no clearing pass is needed.
// Depends on ksd_pkg, ksd_ram and ksd_decode.
module keyboard_scancode_fifo_decoder #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ksd_pkg::ksd_in_t  item,
	output logic              busy,
	output logic              done,
	output ksd_pkg::ksd_out_t result
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HEAD = 2'd1;
	localparam logic [1:0] ST_NEXT = 2'd2;

	logic [1:0]        state_q;
	logic [AW-1:0]     rp_q;
	logic [AW-1:0]     wp_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;
	ksd_pkg::ksd_out_t res_q;

	logic [AW-1:0]     rp_inc;
	logic [AW-1:0]     rp_inc2;
	logic [AW-1:0]     wp_inc;
	logic [AW-1:0]     raddr;
	logic [7:0]        rdata;
	logic              accept;
	logic              push_ok;
	ksd_pkg::ksd_out_t dec_res;

	assign rp_inc  = (rp_q == LAST) ? '0 : rp_q + 1'b1;
	assign rp_inc2 = (rp_inc == LAST) ? '0 : rp_inc + 1'b1;
	assign wp_inc  = (wp_q == LAST) ? '0 : wp_q + 1'b1;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start & ~busy;
	assign push_ok = accept & (item.operation == ksd_pkg::OP_PUSH) & (cnt_q != FULL);
	assign raddr   = (state_q == ST_HEAD) ? rp_inc : rp_q;

	ksd_ram #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (wp_q),
		.wdata (item.scancode),
		.raddr (raddr),
		.rdata (rdata)
	);

	ksd_decode u_decode (
		.ev  (rdata),
		.ext (state_q == ST_NEXT),
		.res (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rp_q    <= '0;
			wp_q    <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.operation == ksd_pkg::OP_PUSH) begin
							done_q <= 1'b1;
							res_q  <= {(cnt_q != FULL), 18'b0};
							if (push_ok) begin
								wp_q  <= wp_inc;
								cnt_q <= cnt_q + 1'b1;
							end
						end else if (cnt_q == '0) begin
							done_q <= 1'b1;
							res_q  <= '0;
						end else begin
							state_q <= ST_HEAD;
						end
					end
				end
				ST_HEAD: begin
					if (rdata == ksd_pkg::PREFIX_EXT) begin
						if (cnt_q == CW'(1)) begin
							done_q  <= 1'b1;
							res_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_NEXT;
						end
					end else begin
						done_q  <= 1'b1;
						res_q   <= dec_res;
						rp_q    <= rp_inc;
						cnt_q   <= cnt_q - CW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_NEXT: begin
					done_q  <= 1'b1;
					res_q   <= dec_res;
					rp_q    <= rp_inc2;
					cnt_q   <= cnt_q - CW'(2);
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

/* sv/ksd_checker.sv */
// Port-level checks on the scancode queue and decoder, bound to the top level.
// Depends on ksd_pkg for the item types.
module ksd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input ksd_pkg::ksd_in_t  item,
	input logic              busy,
	input logic              done,
	input ksd_pkg::ksd_out_t result
);

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result strobe without an item in progress");

	a_push_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.operation == ksd_pkg::OP_PUSH) |=> (done && !busy))
		else $error("push result not delivered in the next cycle");

	a_push_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.accepted) |-> !result.key_ready)
		else $error("push result carries a key event");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.accepted && !result.key_ready) |->
		(result.key_code == '0 && !result.released && !result.extended &&
		 result.character == '0))
		else $error("empty poll result has non-zero fields");

	a_ext_is_key: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.extended) |-> result.key_ready)
		else $error("extended flag without a key event");

endmodule

bind keyboard_scancode_fifo_decoder ksd_checker u_ksd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.item   (item),
	.busy   (busy),
	.done   (done),
	.result (result)
);

/* tb/sv/tb_keyboard_scancode_fifo_decoder.sv */
// Testbench for keyboard_scancode_fifo_decoder: pushes and polls scancode items,
// predicts every key event and checks each strobed result in order.
// Depends on ksd_pkg and the keyboard_scancode_fifo_decoder RTL.
module tb_keyboard_scancode_fifo_decoder;

	import ksd_pkg::*;

	localparam int QDEPTH      = 256;
	localparam int CYCLE_LIMIT = 200000;

	logic     clk;
	logic     arst_n;
	logic     start;
	ksd_in_t  item;
	logic     busy;
	logic     done;
	ksd_out_t result;

	keyboard_scancode_fifo_decoder #(.QUEUE_DEPTH(QDEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	logic [7:0] scan_ring [0:QDEPTH-1];
	int         ring_rd;
	int         ring_wr;
	int         ring_fill;

	ksd_out_t   pending_events [$];
	bit         gaps_on;
	int         errors;
	int         cycles;
	int         items_sent;
	int         events_checked;
	int         pushes_dropped;
	int         key_events;
	int         empty_polls;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic ksd_out_t predict_key_event(ksd_in_t it);
		ksd_out_t   r;
		logic [7:0] ev;
		logic       ext;
		r   = '0;
		ext = 1'b0;
		if (it.operation == OP_PUSH) begin
			if (ring_fill < QDEPTH) begin
				scan_ring[ring_wr] = it.scancode;
				ring_wr = (ring_wr + 1) % QDEPTH;
				ring_fill++;
				r.accepted = 1'b1;
			end else begin
				pushes_dropped++;
			end
			return r;
		end
		if (ring_fill == 0) begin
			empty_polls++;
			return r;
		end
		ev = scan_ring[ring_rd];
		if (ev == PREFIX_EXT) begin
			if (ring_fill < 2) begin
				empty_polls++;
				return r;
			end
			ext = 1'b1;
			ring_rd = (ring_rd + 1) % QDEPTH;
			ring_fill--;
			ev = scan_ring[ring_rd];
		end
		ring_rd = (ring_rd + 1) % QDEPTH;
		ring_fill--;
		key_events++;
		r.key_ready = 1'b1;
		r.key_code  = ev[6:0];
		r.released  = ev[7];
		r.extended  = ext;
		if (ev[6:0] < TABLE_LEN)
			r.character = CHAR_TABLE[ev[6:0]];
		else
			r.character = CHAR_NONE;
		if (ext) begin
			case (ev[6:0])
				KEY_UP:    r.character = CHAR_UP;
				KEY_DOWN:  r.character = CHAR_DOWN;
				KEY_LEFT:  r.character = CHAR_LEFT;
				KEY_RIGHT: r.character = CHAR_RIGHT;
				default: ;
			endcase
		end
		return r;
	endfunction

	task automatic hold_off(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_item(input logic op, input logic [7:0] code);
		ksd_in_t it;
		it.operation = op;
		it.scancode  = code;
		if (gaps_on && $urandom_range(0, 4) == 0)
			hold_off($urandom_range(1, 8));
		@(negedge clk);
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		pending_events.push_back(predict_key_event(it));
		items_sent++;
	endtask

	task automatic push(input logic [7:0] code);
		send_item(OP_PUSH, code);
	endtask

	task automatic poll();
		send_item(OP_POLL, 8'h00);
	endtask

	task automatic wait_all_events();
		@(negedge clk);
		start <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] arrow_byte();
		logic [6:0] k;
		case ($urandom_range(0, 3))
			0:       k = KEY_UP;
			1:       k = KEY_DOWN;
			2:       k = KEY_LEFT;
			default: k = KEY_RIGHT;
		endcase
		return {1'($urandom_range(0, 1)), k};
	endfunction

	task automatic test_directed();
		poll();
		push(PREFIX_EXT);
		poll();
		push({1'b0, KEY_UP});
		poll();
		push(PREFIX_EXT);
		push(PREFIX_EXT);
		poll();
		push(PREFIX_EXT);
		push({1'b1, KEY_UP});
		poll();
		push(PREFIX_EXT);
		push({1'b0, KEY_DOWN});
		push(PREFIX_EXT);
		push({1'b0, KEY_LEFT});
		push(PREFIX_EXT);
		push({1'b0, KEY_RIGHT});
		poll();
		poll();
		poll();
		push(8'h00);
		push(8'hFF);
		poll();
		poll();
		poll();
	endtask

	// fill past the top, then drain through the wrap
	task automatic test_overflow();
		for (int i = 0; i < QDEPTH + 4; i++)
			push(($urandom_range(0, 7) == 0) ? PREFIX_EXT : 8'($urandom_range(0, 255)));
		for (int i = 0; i < QDEPTH + 4; i++)
			poll();
	endtask

	task automatic test_random(input int n);
		int sent;
		int push_bias;
		sent = 0;
		push_bias = 50;
		while (sent < n) begin
			if (sent % 32 == 0)
				push_bias = $urandom_range(20, 80);
			if (sent % 400 == 399)
				wait_all_events();
			if ($urandom_range(0, 99) < push_bias) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						push(PREFIX_EXT);
						push(arrow_byte());
						sent++;
					end
					2: begin
						push(PREFIX_EXT);
						push(8'($urandom_range(0, 255)));
						sent++;
					end
					3: push(8'($urandom_range(0, 255)));
					default: push({1'($urandom_range(0, 1)), 7'($urandom_range(0, 127))});
				endcase
			end else begin
				poll();
			end
			sent++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done !== 1'b0) begin
			if (pending_events.size() == 0) begin
				$display("%0t: result with none expected: %p", $time, result);
				errors++;
			end else begin
				if (result !== pending_events[0]) begin
					$display("%0t: mismatch expected %p actual %p", $time,
						pending_events[0], result);
					errors++;
				end
				void'(pending_events.pop_front());
				events_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_events.size());
			$display("tb_keyboard_scancode_fifo_decoder NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		item           = '0;
		gaps_on        = 1'b1;
		errors         = 0;
		cycles         = 0;
		items_sent     = 0;
		events_checked = 0;
		pushes_dropped = 0;
		key_events     = 0;
		empty_polls    = 0;
		ring_rd        = 0;
		ring_wr        = 0;
		ring_fill      = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		wait_all_events();
		test_overflow();
		wait_all_events();
		test_random(1150);
		gaps_on = 1'b0;
		test_random(150);
		wait_all_events();
		repeat (8) @(posedge clk);

		$display("items %0d, results checked %0d, key events %0d", items_sent,
			events_checked, key_events);
		$display("pushes dropped on full queue %0d, polls with no event %0d",
			pushes_dropped, empty_polls);
		if (errors == 0)
			$display("tb_keyboard_scancode_fifo_decoder OK");
		else
			$display("tb_keyboard_scancode_fifo_decoder NOT OK");
		$finish;
	end

endmodule

/* keyboard_scancode_fifo_decoder.f */
sv/ksd_pkg.sv
sv/ksd_ram.sv
sv/ksd_decode.sv
sv/keyboard_scancode_fifo_decoder.sv
sv/ksd_checker.sv
tb/sv/tb_keyboard_scancode_fifo_decoder.sv
